[design/u8s_pkg.sv]
// Shared types and constants for the UTF-8 sanitizer with Latin-1 fallback.
`default_nettype none
package u8s_pkg;

  localparam int unsigned BUF_DEPTH = 6;
  localparam int unsigned CNT_W     = 3;

  typedef logic [7:0] byte_t;
  typedef byte_t [BUF_DEPTH-1:0] buf_arr_t;

  // Lead byte masks and their match patterns
  localparam byte_t ASCII_MASK = 8'h80;
  localparam byte_t LEAD2_MASK = 8'hE0;
  localparam byte_t LEAD2_PAT  = 8'hC0;
  localparam byte_t LEAD3_MASK = 8'hF0;
  localparam byte_t LEAD3_PAT  = 8'hE0;
  localparam byte_t LEAD4_MASK = 8'hF8;
  localparam byte_t LEAD4_PAT  = 8'hF0;
  localparam byte_t LEAD5_MASK = 8'hFC;
  localparam byte_t LEAD5_PAT  = 8'hF8;
  localparam byte_t LEAD6_MASK = 8'hFE;
  localparam byte_t LEAD6_PAT  = 8'hFC;

  // Continuation byte tag (10xxxxxx) and Latin-1 re-encode bases
  localparam logic [1:0] CONT_TAG  = 2'b10;
  localparam byte_t LATIN_HI_BASE  = 8'hC0;
  localparam byte_t LATIN_LO_BASE  = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PASS,
    ST_LAT_HI,
    ST_LAT_LO
  } state_e;

  // Classifier result for the byte at the head of the buffer
  typedef struct packed {
    logic [CNT_W-1:0] len;
    logic             ascii;
    logic             bad;
  } cls_t;

  // Buffer control from the sequencer
  typedef struct packed {
    logic wr;
    logic shift;
  } buf_ctl_t;

endpackage
`default_nettype wire

[design/u8s_classify.sv]
// Lead byte length decode and continuation check over the pending buffer.
`default_nettype none
module u8s_classify #(
  parameter int unsigned MAX_SEQ_BYTES = 6
) (
  input  wire u8s_pkg::buf_arr_t             buf_i,
  input  wire logic [u8s_pkg::CNT_W-1:0]     count_i,
  output u8s_pkg::cls_t                      cls_o
);

  // Sequence length implied by a lead byte; invalid leads give one
  function automatic logic [u8s_pkg::CNT_W-1:0] seq_len(input u8s_pkg::byte_t b);
    logic [u8s_pkg::CNT_W-1:0] n;
    n = 3'd1;
    if ((b & u8s_pkg::ASCII_MASK) == 8'h00) n = 3'd1;
    else if ((b & u8s_pkg::LEAD2_MASK) == u8s_pkg::LEAD2_PAT) n = 3'd2;
    else if ((b & u8s_pkg::LEAD3_MASK) == u8s_pkg::LEAD3_PAT) n = 3'd3;
    else if ((b & u8s_pkg::LEAD4_MASK) == u8s_pkg::LEAD4_PAT) n = 3'd4;
    else if ((b & u8s_pkg::LEAD5_MASK) == u8s_pkg::LEAD5_PAT) n = 3'd5;
    else if ((b & u8s_pkg::LEAD6_MASK) == u8s_pkg::LEAD6_PAT) n = 3'd6;
    if (n > u8s_pkg::CNT_W'(MAX_SEQ_BYTES)) n = 3'd1;
    return n;
  endfunction

  // Length and ASCII flag of the head byte; bad marks any buffered byte after the lead that is not a continuation byte
  always_comb begin
    cls_o.len   = seq_len(buf_i[0]);
    cls_o.ascii = ~buf_i[0][7];
    cls_o.bad   = 1'b0;
    for (int i = 1; i < int'(u8s_pkg::BUF_DEPTH); i++) begin
      if ((u8s_pkg::CNT_W'(i) < count_i) && (buf_i[i][7:6] != u8s_pkg::CONT_TAG)) begin
        cls_o.bad = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[design/u8s_buffer.sv]
// Pending byte buffer: append at the fill level, shift out at the head.
`default_nettype none
module u8s_buffer (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire u8s_pkg::buf_ctl_t            ctl_i,
  input  wire u8s_pkg::byte_t               wr_byte_i,
  output u8s_pkg::buf_arr_t                 buf_o,
  output logic [u8s_pkg::CNT_W-1:0]         count_o
);

  u8s_pkg::buf_arr_t             buf_q, buf_d;
  logic [u8s_pkg::CNT_W-1:0]     count_q, count_d;

  // Next buffer contents and fill level
  always_comb begin
    buf_d   = buf_q;
    count_d = count_q;
    if (ctl_i.wr) begin
      if (count_q >= u8s_pkg::CNT_W'(u8s_pkg::BUF_DEPTH)) begin
        buf_d[0] = wr_byte_i;
        count_d  = 3'd1;
      end else begin
        buf_d[count_q] = wr_byte_i;
        count_d        = count_q + 3'd1;
      end
    end else if (ctl_i.shift) begin
      for (int i = 0; i < int'(u8s_pkg::BUF_DEPTH) - 1; i++) begin
        buf_d[i] = buf_q[i+1];
      end
      count_d = count_q - 3'd1;
    end
  end

  // Data needs no reset; entries are read only once written
  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign buf_o   = buf_q;
  assign count_o = count_q;

endmodule
`default_nettype wire

[design/utf8_sanitizer_latin1_fallback.sv]
// An accepted byte is written to the pending buffer in the idle state; the scan state
// then decides on the buffer head, and the pass or Latin-1 states load the output
// register once per result byte, holding while stalled. The single output register
// and the sequencer set the pace: a new input byte is taken only back in idle.
// Reset clears the sequencer, fill level and output valid; buffer data is not reset.
`default_nettype none
module utf8_sanitizer_latin1_fallback #(
  parameter int unsigned MAX_SEQ_BYTES = 6
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       is_last_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i
);

  u8s_pkg::state_e               state_q, state_d;
  logic [u8s_pkg::CNT_W-1:0]     rem_q, rem_d;
  logic                          last_q, last_d;
  logic                          out_valid_q, out_valid_d;
  u8s_pkg::byte_t                out_byte_q, out_byte_d;
  logic                          out_last_q, out_last_d;

  u8s_pkg::buf_ctl_t             buf_ctl;
  u8s_pkg::buf_arr_t             pend;
  logic [u8s_pkg::CNT_W-1:0]     count;
  u8s_pkg::cls_t                 cls;

  logic in_acc, out_free, load;
  logic d_pass, d_latin, empty, tail;

  u8s_buffer u_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (buf_ctl),
    .wr_byte_i (in_byte_i),
    .buf_o     (pend),
    .count_o   (count)
  );

  u8s_classify #(
    .MAX_SEQ_BYTES (MAX_SEQ_BYTES)
  ) u_cls (
    .buf_i   (pend),
    .count_i (count),
    .cls_o   (cls)
  );

  // Handshake terms
  assign in_acc   = in_valid_i & ~in_stall_o;
  assign out_free = ~out_valid_q | ~out_stall_i;
  assign empty    = (count == '0);
  assign tail     = last_q & (count == 3'd1);

  // Decision on the buffer head
  assign d_pass  = ((cls.len == 3'd1) & cls.ascii) |
                   ((cls.len != 3'd1) & ~cls.bad & (count >= cls.len));
  assign d_latin = ((cls.len == 3'd1) & ~cls.ascii) |
                   ((cls.len != 3'd1) & cls.bad) |
                   ((cls.len != 3'd1) & ~cls.bad & (count < cls.len) & last_q);

  // Next state
  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    last_d  = last_q;
    unique case (state_q)
      u8s_pkg::ST_IDLE: begin
        if (in_acc) begin
          last_d  = is_last_i;
          state_d = u8s_pkg::ST_SCAN;
        end
      end
      u8s_pkg::ST_SCAN: begin
        if (empty) begin
          state_d = u8s_pkg::ST_IDLE;
        end else if (d_pass) begin
          rem_d   = cls.len;
          state_d = u8s_pkg::ST_PASS;
        end else if (d_latin) begin
          state_d = u8s_pkg::ST_LAT_HI;
        end else begin
          state_d = u8s_pkg::ST_IDLE;
        end
      end
      u8s_pkg::ST_PASS: begin
        if (out_free) begin
          rem_d = rem_q - 3'd1;
          if (rem_q == 3'd1) state_d = u8s_pkg::ST_SCAN;
        end
      end
      u8s_pkg::ST_LAT_HI: begin
        if (out_free) state_d = u8s_pkg::ST_LAT_LO;
      end
      u8s_pkg::ST_LAT_LO: begin
        if (out_free) state_d = u8s_pkg::ST_SCAN;
      end
      default: state_d = u8s_pkg::ST_IDLE;
    endcase
  end

  // Outputs: buffer control and output register load
  always_comb begin
    buf_ctl.wr    = 1'b0;
    buf_ctl.shift = 1'b0;
    load          = 1'b0;
    out_byte_d    = out_byte_q;
    out_last_d    = out_last_q;
    in_stall_o    = 1'b1;
    unique case (state_q)
      u8s_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        buf_ctl.wr = in_valid_i;
      end
      u8s_pkg::ST_SCAN: ;
      u8s_pkg::ST_PASS: begin
        if (out_free) begin
          load          = 1'b1;
          buf_ctl.shift = 1'b1;
          out_byte_d    = pend[0];
          out_last_d    = tail;
        end
      end
      u8s_pkg::ST_LAT_HI: begin
        if (out_free) begin
          load       = 1'b1;
          out_byte_d = u8s_pkg::LATIN_HI_BASE | {6'b0, pend[0][7:6]};
          out_last_d = 1'b0;
        end
      end
      u8s_pkg::ST_LAT_LO: begin
        if (out_free) begin
          load          = 1'b1;
          buf_ctl.shift = 1'b1;
          out_byte_d    = u8s_pkg::LATIN_LO_BASE | {2'b0, pend[0][5:0]};
          out_last_d    = tail;
        end
      end
      default: ;
    endcase
  end

  // Output valid holds while stalled, drops once taken
  assign out_valid_d = load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= u8s_pkg::ST_IDLE;
      rem_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rem_q       <= rem_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

[design/u8s_checker.sv]
// Port-level checker for the UTF-8 sanitizer, bound to the top level.
`default_nettype none
module u8s_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic [7:0] in_byte_i,
  input wire logic       is_last_i,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic [7:0] out_byte_o,
  input wire logic       out_last_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) && $stable(out_last_o))
    else $error("stalled result changed");

  // After an input transaction the block is busy scanning
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("ready right after input transaction");

  // While ready for input no new result is produced
  a_idle_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o && out_valid_o && !out_stall_i |=> !out_valid_o)
    else $error("result produced while idle");

endmodule

bind utf8_sanitizer_latin1_fallback u8s_checker u_chk (.*);
`default_nettype wire

[verif/tb_utf8_sanitizer_latin1_fallback.sv]
// Testbench for the UTF-8 sanitizer: byte-level predictor, scoreboard, directed and random strings.
`timescale 1ns / 100ps
module tb_utf8_sanitizer_latin1_fallback;

  localparam int unsigned SEQ_MAX        = 6;
  localparam int unsigned IDLE_PCT       = 21;
  localparam int unsigned HOLD_CYCLES    = 80;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES    = 16;
  localparam int unsigned MAX_PRINTED    = 50;

  typedef struct packed {
    u8s_pkg::byte_t data;
    logic           last;
  } clean_t;

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic [7:0] in_byte_i   = 8'h00;
  logic       is_last_i   = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] out_byte_o;
  logic       out_last_o;
  logic       out_valid_o;

  // Predictor state: bytes of the sequence still being collected
  u8s_pkg::byte_t pend_bytes[u8s_pkg::BUF_DEPTH];
  int unsigned    pend_cnt = 0;

  clean_t      clean_q[$];
  int unsigned err_cnt      = 0;
  int unsigned sent_cnt     = 0;
  int unsigned src_idle_pct = IDLE_PCT;
  int unsigned snk_idle_pct = IDLE_PCT;
  int unsigned hold_req     = 0;
  int unsigned hold_left    = 0;
  int unsigned quiet_cycles = 0;

  utf8_sanitizer_latin1_fallback #(
    .MAX_SEQ_BYTES(SEQ_MAX)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_byte_i  (in_byte_i),
    .is_last_i  (is_last_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_byte_o (out_byte_o),
    .out_last_o (out_last_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i)
  );

  // 4 ns clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Sequence length implied by a lead byte; 1 for ASCII and for any invalid lead
  function automatic int unsigned lead_len(u8s_pkg::byte_t b);
    int unsigned n;
    if ((b & u8s_pkg::ASCII_MASK) == 8'h00) return 1;
    if ((b & u8s_pkg::LEAD2_MASK) == u8s_pkg::LEAD2_PAT) n = 2;
    else if ((b & u8s_pkg::LEAD3_MASK) == u8s_pkg::LEAD3_PAT) n = 3;
    else if ((b & u8s_pkg::LEAD4_MASK) == u8s_pkg::LEAD4_PAT) n = 4;
    else if ((b & u8s_pkg::LEAD5_MASK) == u8s_pkg::LEAD5_PAT) n = 5;
    else if ((b & u8s_pkg::LEAD6_MASK) == u8s_pkg::LEAD6_PAT) n = 6;
    else return 1;
    if (n > SEQ_MAX || n > u8s_pkg::BUF_DEPTH) return 1;
    return n;
  endfunction

  function automatic void drop_front(int unsigned k);
    for (int unsigned i = 0; i + k < pend_cnt; i++) pend_bytes[i] = pend_bytes[i + k];
    pend_cnt = pend_cnt - k;
  endfunction

  // Re-encode a rejected byte as a two-byte Latin-1 character
  function automatic void push_latin1(u8s_pkg::byte_t b, ref u8s_pkg::byte_t res[$]);
    res.push_back(u8s_pkg::LATIN_HI_BASE | (b >> 6));
    res.push_back(u8s_pkg::LATIN_LO_BASE | (b & 8'h3F));
  endfunction

  // Feed one accepted byte; append the cleaned bytes it releases to clean_q
  task automatic sanitize_byte(u8s_pkg::byte_t b, bit last);
    u8s_pkg::byte_t res[$];
    u8s_pkg::byte_t lead;
    int unsigned    len;
    bit             bad;
    if (pend_cnt >= u8s_pkg::BUF_DEPTH) pend_cnt = 0;
    pend_bytes[pend_cnt] = b;
    pend_cnt++;
    while (pend_cnt > 0) begin
      lead = pend_bytes[0];
      len  = lead_len(lead);
      if (len == 1) begin
        if (lead[7] == 1'b0) res.push_back(lead);
        else push_latin1(lead, res);
        drop_front(1);
        continue;
      end
      bad = 1'b0;
      for (int unsigned i = 1; i < pend_cnt; i++) begin
        if (pend_bytes[i][7:6] != u8s_pkg::CONT_TAG) bad = 1'b1;
      end
      if (bad) begin
        push_latin1(lead, res);
        drop_front(1);
        continue;
      end
      if (pend_cnt >= len) begin
        for (int unsigned i = 0; i < len; i++) res.push_back(pend_bytes[i]);
        drop_front(len);
        continue;
      end
      // incomplete sequence cut off by the end of the string
      if (last) begin
        push_latin1(lead, res);
        drop_front(1);
        continue;
      end
      break;
    end
    if (last) pend_cnt = 0;
    foreach (res[i]) clean_q.push_back('{data: res[i], last: last && (i == res.size() - 1)});
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    if (err_cnt < MAX_PRINTED)
      $display("%0t ns: mismatch on %s: got %02h, want %02h", $realtime, what, got, want);
    err_cnt++;
  endtask

  // Compare each output transaction with the oldest expected byte
  always @(posedge clk_i) begin
    clean_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (clean_q.size() == 0) begin
        report_mismatch("unexpected output byte", out_byte_o, 8'h00);
      end else begin
        want = clean_q.pop_front();
        if (out_byte_o !== want.data) report_mismatch("out_byte", out_byte_o, want.data);
        if (out_last_o !== want.last)
          report_mismatch("out_last", {7'b0, out_last_o}, {7'b0, want.last});
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= (snk_idle_pct != 0) && ($urandom_range(99) < snk_idle_pct);
    end
  end

  // Watchdog: no transaction on either side for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_utf8_sanitizer_latin1_fallback: errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic send_byte(u8s_pkg::byte_t b, bit last);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    is_last_i  <= last;
    do @(posedge clk_i); while (in_stall_o);
    sanitize_byte(b, last);
    sent_cnt++;
  endtask

  task automatic send_string(u8s_pkg::byte_t s[$]);
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
  endtask

  function automatic u8s_pkg::byte_t lead_of(int unsigned len);
    u8s_pkg::byte_t r;
    r = u8s_pkg::byte_t'($urandom);
    case (len)
      1:       r[7]   = 1'b0;
      2:       r[7:5] = 3'b110;
      3:       r[7:4] = 4'b1110;
      4:       r[7:3] = 5'b11110;
      5:       r[7:2] = 6'b111110;
      default: r[7:1] = 7'b1111110;
    endcase
    return r;
  endfunction

  function automatic u8s_pkg::byte_t cont_byte();
    u8s_pkg::byte_t r;
    r      = u8s_pkg::byte_t'($urandom);
    r[7:6] = u8s_pkg::CONT_TAG;
    return r;
  endfunction

  // Mostly well-formed sequences, some broken ones, some noise; may end cut off
  task automatic send_random_string(int unsigned n_seq);
    u8s_pkg::byte_t s[$];
    int unsigned    kind;
    int unsigned    len;
    u8s_pkg::byte_t b;
    repeat (n_seq) begin
      kind = $urandom_range(99);
      if (kind < 62) begin
        len = $urandom_range(1, 6);
        s.push_back(lead_of(len));
        repeat (len - 1) s.push_back(cont_byte());
      end else if (kind < 85) begin
        // lead, too few continuations, then a non-continuation byte
        len = $urandom_range(2, 6);
        s.push_back(lead_of(len));
        repeat ($urandom_range(0, len - 2)) s.push_back(cont_byte());
        b = u8s_pkg::byte_t'($urandom);
        if (b[7:6] == u8s_pkg::CONT_TAG) b[6] = 1'b1;
        s.push_back(b);
      end else begin
        s.push_back(u8s_pkg::byte_t'($urandom));
      end
    end
    if ($urandom_range(99) < 25) begin
      len = $urandom_range(2, 6);
      s.push_back(lead_of(len));
      repeat ($urandom_range(0, len - 2)) s.push_back(cont_byte());
    end
    send_string(s);
  endtask

  // Every lead length, lone continuation, 0xFE/0xFF, bad continuation, cut-off at end
  task automatic test_directed();
    u8s_pkg::byte_t s[$];
    s = '{8'h00, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'h7F};
    send_string(s);
    s = '{8'hF0, 8'h9F, 8'h98, 8'h80, 8'hFC, 8'h84, 8'h80, 8'h80, 8'h80, 8'h80};
    send_string(s);
    s = '{8'hF8, 8'h88, 8'hE2, 8'h41, 8'h80, 8'hFE, 8'hFF};
    send_string(s);
    s = '{8'hE2, 8'h82};
    send_string(s);
  endtask

  task automatic test_random_traffic(int unsigned n_items);
    int unsigned target;
    target = sent_cnt + n_items;
    while (sent_cnt < target) send_random_string($urandom_range(1, 8));
  endtask

  // Receiver holds off while the sender keeps offering: input side must back up
  task automatic test_output_hold();
    int unsigned target;
    target       = sent_cnt + 30;
    src_idle_pct = 0;
    hold_req     = HOLD_CYCLES;
    while (sent_cnt < target) send_random_string($urandom_range(2, 6));
    src_idle_pct = IDLE_PCT;
  endtask

  // Sender stops until every expected byte has come out, then resumes
  task automatic test_drain_pause();
    send_random_string(4);
    send_random_string(3);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (clean_q.size() != 0);
    send_random_string(4);
    send_random_string(3);
  endtask

  // Long stretch at full rate on both sides
  task automatic test_no_idle();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_traffic(45);
    src_idle_pct = IDLE_PCT;
    snk_idle_pct = IDLE_PCT;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_traffic(50);
    test_output_hold();
    test_drain_pause();
    test_no_idle();
    test_random_traffic(20);

    // drain and watch for stray output
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (clean_q.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (clean_q.size() != 0) report_mismatch("missing output bytes", 8'h00, 8'(clean_q.size()));

    if (err_cnt == 0) begin
      $display("tb_utf8_sanitizer_latin1_fallback: clean");
    end else begin
      $display("tb_utf8_sanitizer_latin1_fallback: errors");
    end
    $finish;
  end

endmodule
